[design/ikin_pkg.sv]
package ikin_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int COORD_FRAC_BITS_DEF   = 4;

  localparam int DX_W   = 17;
  localparam int SQ_W   = 33;
  localparam int D2_W   = 34;
  localparam int LSQ_W  = 28;
  localparam int SUMSQ_W = 30;
  localparam int DEN_W  = 29;
  localparam int NUM_W  = 36;
  localparam int NC_W   = 30;
  localparam int XB_W   = 31;
  localparam int RAD_W  = 58;
  localparam int ROOT_W = 29;
  localparam int CIN_W  = 32;
  localparam int ACC_W  = 24;
  localparam int PRESCALE_BITS = 16;
  localparam int CW     = CIN_W + PRESCALE_BITS + 2;

  localparam logic signed [ACC_W-1:0] ACC_QUARTER = ACC_W'(1474560);
  localparam logic signed [16:0] FULL_TURN = 17'sd23040;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FLOOR = 2'd1;
  localparam logic [1:0] ST_REACH = 2'd2;
  localparam logic [1:0] ST_LIMIT = 2'd3;

  typedef enum logic [2:0] {
    REG_BASE_X       = 3'd0,
    REG_BASE_Y       = 3'd1,
    REG_LINK1        = 3'd2,
    REG_LINK2        = 3'd3,
    REG_SHOULDER_MIN = 3'd4,
    REG_SHOULDER_MAX = 3'd5,
    REG_ELBOW_MIN    = 3'd6,
    REG_ELBOW_MAX    = 3'd7
  } ikin_reg_t;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
  } ikin_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] shoulder_angle;
    logic [13:0] elbow_angle;
  } ikin_out_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DX_W-1:0]  dx;
    logic signed [DX_W-1:0]  dy;
    logic signed [NC_W-1:0]  num;
    logic signed [XB_W-1:0]  xb;
  } ikin_side_t;

  function automatic logic signed [ACC_W-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ACC_W-1:0] v;
    unique case (idx)
      5'd0:  v = ACC_W'(737280);
      5'd1:  v = ACC_W'(435242);
      5'd2:  v = ACC_W'(229970);
      5'd3:  v = ACC_W'(116736);
      5'd4:  v = ACC_W'(58595);
      5'd5:  v = ACC_W'(29326);
      5'd6:  v = ACC_W'(14667);
      5'd7:  v = ACC_W'(7334);
      5'd8:  v = ACC_W'(3667);
      5'd9:  v = ACC_W'(1833);
      5'd10: v = ACC_W'(917);
      5'd11: v = ACC_W'(458);
      5'd12: v = ACC_W'(229);
      5'd13: v = ACC_W'(115);
      5'd14: v = ACC_W'(57);
      5'd15: v = ACC_W'(29);
      5'd16: v = ACC_W'(14);
      5'd17: v = ACC_W'(7);
      5'd18: v = ACC_W'(4);
      5'd19: v = ACC_W'(2);
      5'd20: v = ACC_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[design/ikin_geom.sv]
module ikin_geom
  import ikin_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  ikin_in_t                tgt_i,
  input  logic signed [15:0]      base_x,
  input  logic signed [15:0]      base_y,
  input  logic [13:0]             l1,
  input  logic [13:0]             l2,
  output logic                    vld_o,
  output logic [RAD_W-1:0]        rad_o,
  output ikin_side_t              side_o
);

  logic [7:1] vld_r;

  // stage 1: offsets from the base
  logic signed [DX_W-1:0] dx1_r, dy1_r;
  logic                   below1_r;
  // stage 2: squares
  logic signed [DX_W-1:0] dx2_r, dy2_r;
  logic                   below2_r, zero2_r;
  logic [SQ_W-1:0]        dxsq2_r, dysq2_r;
  logic [LSQ_W-1:0]       l1sq2_r, l2sq2_r, l12_2_r, diffsq2_r;
  logic [SUMSQ_W-1:0]     sumsq2_r;
  // stage 3: sums
  logic signed [DX_W-1:0] dx3_r, dy3_r;
  logic                   below3_r, zero3_r;
  logic [D2_W-1:0]        d2_3_r;
  logic [LSQ_W:0]         lsum3_r;
  logic [LSQ_W-1:0]       l1sq3_r, diffsq3_r;
  logic [SUMSQ_W-1:0]     sumsq3_r;
  logic [DEN_W-1:0]       den3_r;
  // stage 4: law of cosines numerator, reach test
  logic signed [DX_W-1:0] dx4_r, dy4_r;
  logic [1:0]             st4_r;
  logic signed [NUM_W-1:0] num4_r;
  logic [DEN_W-1:0]       den4_r;
  logic [LSQ_W-1:0]       l1sq4_r;
  // stage 5: clamp
  logic signed [DX_W-1:0] dx5_r, dy5_r;
  logic [1:0]             st5_r;
  logic signed [NC_W-1:0] numc5_r;
  logic [DEN_W-1:0]       nabs5_r, den5_r;
  logic [LSQ_W-1:0]       l1sq5_r;
  // stage 6: squares of den and num
  ikin_side_t             side6_r;
  logic [RAD_W-1:0]       densq6_r, numsq6_r;
  // stage 7
  ikin_side_t             side7_r;
  logic [RAD_W-1:0]       rad7_r;

  logic signed [16:0]     dx_c, dy_c;
  logic [14:0]            lsum_c, ldiff_c;
  logic signed [NUM_W-1:0] num_c;
  logic                   reach_bad_c;
  logic [1:0]             st_c;
  logic                   neg_c;
  logic [NUM_W-1:0]       mag_c;
  logic [DEN_W-1:0]       magc_c;
  logic signed [NC_W-1:0] numc_c;
  ikin_side_t             side_c;

  always_comb begin
    dx_c = {tgt_i.target_x[15], tgt_i.target_x} - {base_x[15], base_x};
    dy_c = {base_y[15], base_y} - {tgt_i.target_y[15], tgt_i.target_y};
    lsum_c = {1'b0, l1} + {1'b0, l2};
    ldiff_c = (l1 > l2) ? 15'({1'b0, l1} - {1'b0, l2}) : 15'({1'b0, l2} - {1'b0, l1});
    num_c = $signed({2'b00, d2_3_r}) - $signed({{(NUM_W-LSQ_W-1){1'b0}}, lsum3_r});
    reach_bad_c = zero3_r || (d2_3_r > D2_W'(sumsq3_r)) || (d2_3_r < D2_W'(diffsq3_r));
    if (below3_r) begin
      st_c = ST_FLOOR;
    end else if (reach_bad_c) begin
      st_c = ST_REACH;
    end else begin
      st_c = ST_OK;
    end
    neg_c = num4_r[NUM_W-1];
    mag_c = neg_c ? NUM_W'(-num4_r) : NUM_W'(num4_r);
    magc_c = (mag_c > NUM_W'(den4_r)) ? den4_r : mag_c[DEN_W-1:0];
    numc_c = neg_c ? -$signed({1'b0, magc_c}) : $signed({1'b0, magc_c});
    side_c.status = st5_r;
    side_c.dx = dx5_r;
    side_c.dy = dy5_r;
    side_c.num = numc5_r;
    side_c.xb = $signed({2'b00, l1sq5_r, 1'b0}) + XB_W'(numc5_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[6:1], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r <= dx_c;
      dy1_r <= dy_c;
      below1_r <= tgt_i.target_y > base_y;

      dx2_r <= dx1_r;
      dy2_r <= dy1_r;
      below2_r <= below1_r;
      zero2_r <= (l1 == '0) || (l2 == '0);
      dxsq2_r <= SQ_W'(dx1_r * dx1_r);
      dysq2_r <= SQ_W'(dy1_r * dy1_r);
      l1sq2_r <= l1 * l1;
      l2sq2_r <= l2 * l2;
      l12_2_r <= l1 * l2;
      sumsq2_r <= lsum_c * lsum_c;
      diffsq2_r <= LSQ_W'(ldiff_c * ldiff_c);

      dx3_r <= dx2_r;
      dy3_r <= dy2_r;
      below3_r <= below2_r;
      zero3_r <= zero2_r;
      d2_3_r <= {1'b0, dxsq2_r} + {1'b0, dysq2_r};
      lsum3_r <= {1'b0, l1sq2_r} + {1'b0, l2sq2_r};
      l1sq3_r <= l1sq2_r;
      diffsq3_r <= diffsq2_r;
      sumsq3_r <= sumsq2_r;
      den3_r <= {l12_2_r, 1'b0};

      dx4_r <= dx3_r;
      dy4_r <= dy3_r;
      st4_r <= st_c;
      num4_r <= num_c;
      den4_r <= den3_r;
      l1sq4_r <= l1sq3_r;

      dx5_r <= dx4_r;
      dy5_r <= dy4_r;
      st5_r <= st4_r;
      numc5_r <= numc_c;
      nabs5_r <= magc_c;
      den5_r <= den4_r;
      l1sq5_r <= l1sq4_r;

      side6_r <= side_c;
      densq6_r <= den5_r * den5_r;
      numsq6_r <= nabs5_r * nabs5_r;

      side7_r <= side6_r;
      rad7_r <= densq6_r - numsq6_r;
    end
  end

  assign vld_o  = vld_r[7];
  assign rad_o  = rad7_r;
  assign side_o = side7_r;

endmodule

[design/ikin_isqrt.sv]
module ikin_isqrt
  import ikin_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  ikin_side_t        side_i,
  output logic              vld_o,
  output logic [ROOT_W-1:0] root_o,
  output ikin_side_t        side_o
);

  localparam int TW = RAD_W + 1;

  logic [RAD_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] q_r    [ROOT_W];
  ikin_side_t        side_r [ROOT_W];
  logic [ROOT_W-1:0] vld_r;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    localparam int K = ROOT_W - 1 - j;
    logic [RAD_W-1:0]  rem_in;
    logic [ROOT_W-1:0] q_in;
    ikin_side_t        side_in;
    logic              vld_in;
    logic [TW-1:0]     trial;
    logic              take;

    if (j == 0) begin : g_first
      assign rem_in  = rad_i;
      assign q_in    = '0;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign q_in    = q_r[j-1];
      assign side_in = side_r[j-1];
      assign vld_in  = vld_r[j-1];
    end

    assign trial = (TW'(q_in) << (K + 1)) | (TW'(1) << (2 * K));
    assign take  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= take ? RAD_W'({1'b0, rem_in} - trial) : rem_in;
        q_r[j]    <= take ? (q_in | (ROOT_W'(1) << K)) : q_in;
        side_r[j] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[ROOT_W-1];
  assign root_o = q_r[ROOT_W-1];
  assign side_o = side_r[ROOT_W-1];

endmodule

[design/ikin_cordic.sv]
module ikin_cordic
  import ikin_pkg::*;
#(
  parameter int ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [CIN_W-1:0] x_i,
  input  logic signed [CIN_W-1:0] y_i,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [CW-1:0]    x_r   [ITERATIONS+1];
  logic signed [CW-1:0]    y_r   [ITERATIONS+1];
  logic signed [ACC_W-1:0] acc_r [ITERATIONS+1];

  logic signed [CW-1:0] xs_c, ys_c;

  always_comb begin
    xs_c = {{(CW-CIN_W-PRESCALE_BITS){x_i[CIN_W-1]}}, x_i, {PRESCALE_BITS{1'b0}}};
    ys_c = {{(CW-CIN_W-PRESCALE_BITS){y_i[CIN_W-1]}}, y_i, {PRESCALE_BITS{1'b0}}};
  end

  // quadrant fold into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      if (!xs_c[CW-1]) begin
        x_r[0]   <= xs_c;
        y_r[0]   <= ys_c;
        acc_r[0] <= '0;
      end else if (!ys_c[CW-1]) begin
        x_r[0]   <= ys_c;
        y_r[0]   <= -xs_c;
        acc_r[0] <= ACC_QUARTER;
      end else begin
        x_r[0]   <= -ys_c;
        y_r[0]   <= xs_c;
        acc_r[0] <= -ACC_QUARTER;
      end
    end
  end

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    logic signed [CW-1:0]    xsh, ysh;
    logic signed [ACC_W-1:0] ang;
    assign xsh = x_r[i] >>> i;
    assign ysh = y_r[i] >>> i;
    assign ang = atan_lut(5'(i));

    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[i][CW-1]) begin
          x_r[i+1]   <= x_r[i] + ysh;
          y_r[i+1]   <= y_r[i] - xsh;
          acc_r[i+1] <= acc_r[i] + ang;
        end else begin
          x_r[i+1]   <= x_r[i] - ysh;
          y_r[i+1]   <= y_r[i] + xsh;
          acc_r[i+1] <= acc_r[i] - ang;
        end
      end
    end
  end

  assign acc_o = acc_r[ITERATIONS];

endmodule

[design/two_link_inverse_kinematics.sv]
// Two-link planar inverse kinematics, elbow-down. One target point per request, one
// result per request, in order. The datapath is a single pipeline: 7 geometry stages,
// a 29-stage square root (one root bit per stage), CORDIC_ITERATIONS+1 stages of three
// parallel vectoring CORDICs and 2 stages of rounding and limit checks. A new target
// is taken every cycle while the sink takes results; all stages share one enable, so a
// result that the sink does not take holds the whole pipeline. The user must write
// registers only with the pipeline empty; the block itself does not enforce it.
module two_link_inverse_kinematics
  import ikin_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
  parameter int COORD_FRAC_BITS   = COORD_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  ikin_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output ikin_out_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int LAT = CORDIC_ITERATIONS + 1;

  logic signed [15:0] base_x_r, base_y_r;
  logic [13:0]        l1_r, l2_r;
  logic signed [15:0] smin_r, smax_r, emin_r, emax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_x_r <= 16'(300 << COORD_FRAC_BITS);
      base_y_r <= 16'(450 << COORD_FRAC_BITS);
      l1_r     <= 14'(150 << COORD_FRAC_BITS);
      l2_r     <= 14'(100 << COORD_FRAC_BITS);
      smin_r   <= 16'sd0;
      smax_r   <= 16'sd11520;
      emin_r   <= -16'sd10880;
      emax_r   <= 16'sd10880;
    end else if (cfg_we) begin
      unique case (ikin_reg_t'(cfg_index))
        REG_BASE_X:       base_x_r <= cfg_wdata;
        REG_BASE_Y:       base_y_r <= cfg_wdata;
        REG_LINK1:        l1_r     <= cfg_wdata[13:0];
        REG_LINK2:        l2_r     <= cfg_wdata[13:0];
        REG_SHOULDER_MIN: smin_r   <= cfg_wdata;
        REG_SHOULDER_MAX: smax_r   <= cfg_wdata;
        REG_ELBOW_MIN:    emin_r   <= cfg_wdata;
        REG_ELBOW_MAX:    emax_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_r;
  ikin_out_t out_r;

  assign en       = out_ready || !out_vld_r;
  assign in_ready = en;

  logic              g_vld;
  logic [RAD_W-1:0]  g_rad;
  ikin_side_t        g_side;
  logic              q_vld;
  logic [ROOT_W-1:0] q_root;
  ikin_side_t        q_side;

  ikin_geom u_geom (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_valid),
    .tgt_i  (in_data),
    .base_x (base_x_r),
    .base_y (base_y_r),
    .l1     (l1_r),
    .l2     (l2_r),
    .vld_o  (g_vld),
    .rad_o  (g_rad),
    .side_o (g_side)
  );

  ikin_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (g_vld),
    .rad_i  (g_rad),
    .side_i (g_side),
    .vld_o  (q_vld),
    .root_o (q_root),
    .side_o (q_side)
  );

  logic signed [CIN_W-1:0] root_c;
  logic signed [ACC_W-1:0] acc_e, acc_t, acc_b;

  assign root_c = $signed({{(CIN_W-ROOT_W){1'b0}}, q_root});

  // elbow angle
  ikin_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_elbow (
    .clk   (clk),
    .en    (en),
    .x_i   (CIN_W'(q_side.num)),
    .y_i   (root_c),
    .acc_o (acc_e)
  );

  // direction to the target
  ikin_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_target (
    .clk   (clk),
    .en    (en),
    .x_i   (CIN_W'(q_side.dx)),
    .y_i   (CIN_W'(q_side.dy)),
    .acc_o (acc_t)
  );

  // offset of the first link from the target direction
  ikin_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_offset (
    .clk   (clk),
    .en    (en),
    .x_i   (CIN_W'(q_side.xb)),
    .y_i   (root_c),
    .acc_o (acc_b)
  );

  logic [LAT-1:0] d_vld_r;
  logic [1:0]     d_st_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= '0;
    end else if (en) begin
      d_vld_r <= {d_vld_r[LAT-2:0], q_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_st_r[0] <= q_side.status;
      for (int k = 1; k < LAT; k++) begin
        d_st_r[k] <= d_st_r[k-1];
      end
    end
  end

  logic signed [ACC_W-1:0] e_sum_c;
  logic signed [ACC_W:0]   s_sum_c;
  logic                    r_vld_r;
  logic [1:0]              r_st_r;
  logic signed [15:0]      r_a2_r;
  logic signed [16:0]      r_a1_r;

  always_comb begin
    e_sum_c = acc_e + ACC_W'(128);
    s_sum_c = {acc_t[ACC_W-1], acc_t} - {acc_b[ACC_W-1], acc_b} + (ACC_W+1)'(128);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r <= 1'b0;
    end else if (en) begin
      r_vld_r <= d_vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_st_r <= d_st_r[LAT-1];
      r_a2_r <= e_sum_c[ACC_W-1:8];
      r_a1_r <= s_sum_c[ACC_W:8];
    end
  end

  logic signed [16:0] a1_c;
  logic               viol_c;
  ikin_out_t          out_nxt;

  always_comb begin
    a1_c = r_a1_r[16] ? (r_a1_r + FULL_TURN) : r_a1_r;
    viol_c = (a1_c < $signed({smin_r[15], smin_r})) || (a1_c > $signed({smax_r[15], smax_r}))
          || (r_a2_r < emin_r) || (r_a2_r > emax_r);
    if (r_st_r != ST_OK) begin
      out_nxt.status         = r_st_r;
      out_nxt.shoulder_angle = '0;
      out_nxt.elbow_angle    = '0;
    end else begin
      out_nxt.status         = viol_c ? ST_LIMIT : ST_OK;
      out_nxt.shoulder_angle = a1_c[14:0];
      out_nxt.elbow_angle    = r_a2_r[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= r_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_rejected_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FLOOR || out_data.status == ST_REACH)
    |-> out_data.shoulder_angle == '0 && out_data.elbow_angle == '0)
    else $error("rejected target carries angles");
  a_elbow_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_OK |-> out_data.elbow_angle <= 14'd11520)
    else $error("elbow angle out of range");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !r_vld_r)
    else $error("pipeline not empty after reset");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(d_vld_r) && $stable(r_vld_r))
    else $error("pipeline moved during stall");
`endif

endmodule
